// ===== rtl/aes_pkg.sv =====
// Package for the AES block encryptor: payload and control structs,
// FSM state type, register indexes, S-box, Rcon and GF(2^8) helpers.
// No dependencies.
`default_nettype none
package aes_pkg;

    typedef struct packed {
        logic [63:0] plain_upper;
        logic [63:0] plain_lower;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] cipher_upper;
        logic [63:0] cipher_lower;
    } aes_out_t;

    // per-cell key schedule control for the current round
    typedef struct packed {
        logic        use_key;   // word comes straight from the key registers
        logic [31:0] key_word;
        logic        rot;       // RotWord + SubWord + Rcon
        logic        sub;       // SubWord only (256-bit key, i mod 8 == 4)
        logic [7:0]  rcon;
    } key_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } fsm_t;

    localparam logic [2:0] CFG_KEY0 = 3'd0;
    localparam logic [2:0] CFG_KEY1 = 3'd1;
    localparam logic [2:0] CFG_KEY2 = 3'd2;
    localparam logic [2:0] CFG_KEY3 = 3'd3;
    localparam logic [2:0] CFG_MODE = 3'd4;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_256 = 2'd2;

    localparam int CELLS = 4;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/aes_block_encrypt_top.sv =====
// AES-128/192/256 forward encryption top level: configuration registers,
// round sequencer and a row of four aes_cell instances. Uses aes_pkg.
// The block runs Nr rounds (10, 12 or 14, one round per cycle unless the final round
// is held) and the result is then captured into the output register before it is offered.
// The single round unit row takes no new block until the current one has left the rounds;
// the final round holds while the previous result still waits.
// Reset (aresetn low, synchronous): key registers and mode clear to zero,
// sequencer returns to idle and the output register empties.
`default_nettype none
module aes_block_encrypt_top (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire aes_pkg::aes_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output aes_pkg::aes_out_t     m_data,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [63:0]      cfg_wdata
);
    import aes_pkg::*;

    // configuration
    logic [3:0][63:0] key_reg;
    logic [1:0]       mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg  <= '0;
            mode_reg <= MODE_128;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_KEY0: key_reg[0] <= cfg_wdata;
                CFG_KEY1: key_reg[1] <= cfg_wdata;
                CFG_KEY2: key_reg[2] <= cfg_wdata;
                CFG_KEY3: key_reg[3] <= cfg_wdata;
                CFG_MODE: mode_reg   <= cfg_wdata[1:0];
                default:  ;   // drop writes beyond the register list
            endcase
        end
    end

    // mode three saturates to the 256-bit key
    logic [1:0] mode;
    logic [3:0] nk, nr;
    assign mode = (mode_reg > MODE_256) ? MODE_256 : mode_reg;
    assign nk   = 4'd4  + {1'b0, mode, 1'b0};
    assign nr   = 4'd10 + {1'b0, mode, 1'b0};

    // sequencer
    fsm_t       state_reg, state_next;
    logic [3:0] round_reg;
    logic [2:0] mod_reg;      // (4 * round) mod Nk
    logic [3:0] quot_reg;     // (4 * round) div Nk
    logic       out_valid_reg;
    aes_out_t   out_reg;
    logic       accept, load, adv, last;

    assign accept = s_valid && s_ready;
    assign last   = (round_reg == nr);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RUN;
            ST_RUN:  if (adv && last) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        load    = (state_reg == ST_IDLE) && s_valid;
        // hold the final round while the previous result is still waiting
        adv     = (state_reg == ST_RUN) && !(last && out_valid_reg && !m_ready);
    end

    logic [3:0] mod_sum, mod_sub;
    logic       mod_wrap;
    assign mod_sum  = {1'b0, mod_reg} + 4'd4;
    assign mod_wrap = (mod_sum >= nk);
    assign mod_sub  = mod_sum - nk;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            mod_reg   <= '0;
            quot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (adv && last) begin
                round_reg <= '0;
                mod_reg   <= '0;
                quot_reg  <= '0;
            end else if (load || adv) begin
                round_reg <= round_reg + 4'd1;
                mod_reg   <= mod_wrap ? mod_sub[2:0] : mod_sum[2:0];
                quot_reg  <= quot_reg + {3'b0, mod_wrap};
            end
        end
    end

    // key schedule control per cell: word index is 4*round + cell
    key_ctl_t [CELLS-1:0] ctl;
    always_comb begin
        logic [5:0] idx;
        logic [3:0] mraw, m;
        logic       wrap;
        for (int j = 0; j < CELLS; j++) begin
            idx  = {round_reg, 2'b00} + 6'(j);
            mraw = {1'b0, mod_reg} + 4'(j);
            wrap = (mraw >= nk);
            m    = wrap ? (mraw - nk) : mraw;
            ctl[j].use_key  = (idx < {2'b00, nk});
            ctl[j].key_word = idx[0] ? key_reg[idx[2:1]][31:0] : key_reg[idx[2:1]][63:32];
            ctl[j].rot      = (m == 4'd0);
            ctl[j].sub      = (mode == MODE_256) && (m == 4'd4);
            ctl[j].rcon     = rcon(quot_reg + {3'b0, wrap});
        end
    end

    // cell row
    logic [CELLS-1:0][31:0] col_q, prev1_q, prev2_q, new_word;
    logic [CELLS-1:0][31:0] sh, w_prev, w_back, plain_col;

    assign plain_col = {s_data.plain_lower[31:0], s_data.plain_lower[63:32],
                        s_data.plain_upper[31:0], s_data.plain_upper[63:32]};

    always_comb begin
        for (int c = 0; c < CELLS; c++) begin
            // ShiftRows: row r of column c comes from column c + r
            for (int r = 0; r < 4; r++) begin
                sh[c][31-8*r -: 8] = col_q[2'(c + r)][31-8*r -: 8];
            end
            w_prev[c] = (c == 0) ? prev1_q[CELLS-1] : new_word[(c == 0) ? 0 : c-1];
            case (mode)
                MODE_128: w_back[c] = prev1_q[c];
                MODE_256: w_back[c] = prev2_q[c];
                default:  w_back[c] = (c < 2) ? prev2_q[2'(c + 2)] : prev1_q[2'(c - 2)];
            endcase
        end
    end

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        aes_cell u_cell (
            .aclk      (aclk),
            .load      (load),
            .advance   (adv),
            .last      (last),
            .plain_col (plain_col[g]),
            .sh_bytes  (sh[g]),
            .ctl       (ctl[g]),
            .w_prev    (w_prev[g]),
            .w_back    (w_back[g]),
            .col_q     (col_q[g]),
            .prev1_q   (prev1_q[g]),
            .prev2_q   (prev2_q[g]),
            .new_word  (new_word[g])
        );
    end

    // output register: capture the final round, release on the m_ transaction
    logic [CELLS-1:0][31:0] fin_col;
    always_comb begin
        for (int c = 0; c < CELLS; c++) begin
            fin_col[c] = col_q[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && last) begin
            out_valid_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    logic [CELLS-1:0][31:0] res_col;
    always_comb begin
        for (int c = 0; c < CELLS; c++) begin
            res_col[c] = 32'h0;
        end
    end

    // the cells write the final column into col_reg; capture it the cycle after
    logic cap_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= 1'b0;
        end else begin
            cap_reg <= adv && last;
        end
    end

    always_ff @(posedge aclk) begin
        if (cap_reg) begin
            out_reg.cipher_upper <= {fin_col[0], fin_col[1]} | {res_col[0], res_col[1]};
            out_reg.cipher_lower <= {fin_col[2], fin_col[3]} | {res_col[2], res_col[3]};
        end
    end

    // data is valid once cap_reg has fallen and out_reg holds the captured final round
    logic out_show;
    assign out_show = out_valid_reg && !cap_reg;
    assign m_valid  = out_show;
    assign m_data   = out_reg;

    // a new block may only start while the round counter sits at zero
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (round_reg == 4'd0))
        else $error("block accepted while rounds in flight");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (round_reg <= nr))
        else $error("round counter beyond Nr");

    a_mod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, mod_reg} < nk))
        else $error("schedule phase outside Nk");

    a_out_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RUN))
        else $error("result raised outside a run");

endmodule
`default_nettype wire

// ===== rtl/aes_cell.sv =====
// One cell of the AES chain: holds one state column and two key-schedule
// words, does one round on its column and makes one schedule word. Uses aes_pkg.
`default_nettype none
module aes_cell (
    input  wire logic             aclk,
    input  wire logic             load,
    input  wire logic             advance,
    input  wire logic             last,
    input  wire logic [31:0]      plain_col,
    input  wire logic [31:0]      sh_bytes,
    input  wire aes_pkg::key_ctl_t ctl,
    input  wire logic [31:0]      w_prev,
    input  wire logic [31:0]      w_back,
    output logic [31:0]           col_q,
    output logic [31:0]           prev1_q,
    output logic [31:0]           prev2_q,
    output logic [31:0]           new_word
);
    import aes_pkg::*;

    logic [31:0] col_reg, prev1_reg, prev2_reg;
    logic [31:0] col_next;
    logic [31:0] t;
    logic [7:0]  a0, a1, a2, a3, all;
    logic [31:0] rnd;

    always_comb begin
        if (ctl.rot) begin
            t = sub_word({w_prev[23:0], w_prev[31:24]}) ^ {ctl.rcon, 24'h0};
        end else if (ctl.sub) begin
            t = sub_word(w_prev);
        end else begin
            t = w_prev;
        end
        new_word = ctl.use_key ? ctl.key_word : (w_back ^ t);
    end

    always_comb begin
        a0  = sbox(sh_bytes[31:24]);
        a1  = sbox(sh_bytes[23:16]);
        a2  = sbox(sh_bytes[15:8]);
        a3  = sbox(sh_bytes[7:0]);
        all = a0 ^ a1 ^ a2 ^ a3;
        if (last) begin
            rnd = {a0, a1, a2, a3};
        end else begin
            rnd = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                   a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
        end
        col_next = (load ? plain_col : rnd) ^ new_word;
    end

    always_ff @(posedge aclk) begin
        if (load || advance) begin
            col_reg   <= col_next;
            prev1_reg <= new_word;
            prev2_reg <= prev1_reg;
        end
    end

    assign col_q   = col_reg;
    assign prev1_q = prev1_reg;
    assign prev2_q = prev2_reg;

endmodule
`default_nettype wire

// ===== dv/aes_block_encrypt_top_tb.sv =====
// Self-checking testbench for aes_block_encrypt_top: drives plaintext blocks
// under random flow control and compares each ciphertext with an in-bench AES model.
// Depends on rtl/aes_pkg.sv (payload structs, register indexes) and the DUT.
`default_nettype none
module aes_block_encrypt_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import aes_pkg::*;

    localparam int SCHED_DEPTH = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_SAT = 2'd3;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    aes_in_t    s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    aes_out_t   m_data;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_wdata = '0;

    aes_block_encrypt_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bench copy of the key registers and an independent S-box.
    logic [63:0] key_shadow [4];
    logic [1:0]  mode_shadow;
    logic [7:0]  sb [256];

    aes_in_t  plain_q [$];
    aes_out_t cipher_q [$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    bit  hold_rx = 1'b0;
    int  hold_rx_len = 0;

    // Build the S-box from the GF(2^8) inverse and the affine map.
    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] xt(logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] subw(logic [31:0] w);
        return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
    endfunction

    function automatic aes_out_t encipher(aes_in_t blk);
        logic [31:0] w [SCHED_DEPTH];
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [31:0] t;
        logic [7:0]  rc, x;
        int nk, nr, m;
        aes_out_t r;
        m  = (mode_shadow > 2) ? 2 : mode_shadow;
        nk = 4 + 2 * m;
        nr = 10 + 2 * m;
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            w[i] = i[0] ? key_shadow[i/2][31:0] : key_shadow[i/2][63:32];
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            t = w[i-1];
            if (i % nk == 0) begin
                t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = xt(rc);
            end else if (nk == 8 && i % nk == 4) begin
                t = subw(t);
            end
            w[i] = w[i-nk] ^ t;
        end
        for (int i = 0; i < 8; i++) begin
            st[i]   = blk.plain_upper[63-8*i -: 8];
            st[8+i] = blk.plain_lower[63-8*i -: 8];
        end
        for (int rd = 0; rd <= nr; rd++) begin
            if (rd > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int rr = 0; rr < 4; rr++)
                        tmp[4*c+rr] = sb[st[4*((c+rr)%4)+rr]];
                st = tmp;
                if (rd < nr)
                    for (int c = 0; c < 4; c++) begin
                        x = st[4*c] ^ st[4*c+1] ^ st[4*c+2] ^ st[4*c+3];
                        tmp[4*c]   = st[4*c]   ^ x ^ xt(st[4*c]   ^ st[4*c+1]);
                        tmp[4*c+1] = st[4*c+1] ^ x ^ xt(st[4*c+1] ^ st[4*c+2]);
                        tmp[4*c+2] = st[4*c+2] ^ x ^ xt(st[4*c+2] ^ st[4*c+3]);
                        tmp[4*c+3] = st[4*c+3] ^ x ^ xt(st[4*c+3] ^ st[4*c]);
                        for (int b = 0; b < 4; b++)
                            st[4*c+b] = tmp[4*c+b];
                    end
            end
            for (int c = 0; c < 4; c++)
                for (int b = 0; b < 4; b++)
                    st[4*c+b] ^= w[4*rd+c][31-8*b -: 8];
        end
        for (int i = 0; i < 8; i++) begin
            r.cipher_upper[63-8*i -: 8] = st[i];
            r.cipher_lower[63-8*i -: 8] = st[8+i];
        end
        return r;
    endfunction

    // Driver: offer the head of the plaintext queue; advance on each transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                cipher_q.push_back(encipher(s_data));
                void'(plain_q.pop_front());
            end
            if (s_valid && !s_ready) begin
                // hold valid and payload until the transaction happens
            end else if (plain_q.size() > (s_valid && s_ready ? 0 : 0) &&
                         (!idle_on || $urandom_range(99) >= 19)) begin
                s_valid <= 1'b1;
                s_data  <= plain_q[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: sample each result transaction and check it against the oldest expectation.
    always @(posedge aclk) begin
        aes_out_t want;
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (cipher_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected ciphertext %h", m_data);
                end else begin
                    want = cipher_q.pop_front();
                    if (m_data.cipher_upper !== want.cipher_upper ||
                        m_data.cipher_lower !== want.cipher_lower) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ciphertext mismatch: exp %h_%h got %h_%h",
                                     want.cipher_upper, want.cipher_lower,
                                     m_data.cipher_upper, m_data.cipher_lower);
                    end
                end
            end
            // Long receiver hold-off, counted here, lets the block back up.
            if (hold_rx_len > 0) begin
                hold_rx_len <= hold_rx_len - 1;
                m_ready <= 1'b0;
            end else if (hold_rx) begin
                hold_rx_len <= 300;
                hold_rx <= 1'b0;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !idle_on || $urandom_range(99) >= 19;
            end
        end
    end

    // Cycle limit guards against a hung handshake.
    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx < CFG_MODE) key_shadow[idx] = val;
        else if (idx == CFG_MODE) mode_shadow = val[1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every queued block is sent and every expected ciphertext is received, then idle on.
    task automatic drain();
        while (plain_q.size() != 0 || s_valid || cipher_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_key(logic [1:0] mode, bit extreme, logic [63:0] fill);
        for (int i = 0; i < 4; i++)
            write_reg(i[2:0], extreme ? fill : {$urandom, $urandom});
        write_reg(CFG_MODE, {62'b0, mode});
    endtask

    task automatic queue_random(int n);
        aes_in_t p;
        for (int i = 0; i < n; i++) begin
            p.plain_upper = {$urandom, $urandom};
            p.plain_lower = {$urandom, $urandom};
            plain_q.push_back(p);
        end
    endtask

    initial begin
        logic [7:0] inv;
        logic [1:0] modes [4];
        for (int a = 0; a < 256; a++) begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++)
                if (gmul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
            sb[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                    {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
        for (int i = 0; i < 4; i++) key_shadow[i] = '0;
        mode_shadow = MODE_128;
        modes = '{MODE_128, MODE_192, MODE_256, MODE_SAT};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset key, then extremes of key and data for every mode.
        plain_q.push_back('{64'h0, 64'h0});
        plain_q.push_back('{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
        drain();
        foreach (modes[m]) begin
            set_key(modes[m], 1'b1, (m % 2) ? 64'h0 : 64'hffff_ffff_ffff_ffff);
            plain_q.push_back('{64'h0, 64'hffff_ffff_ffff_ffff});
            plain_q.push_back('{64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff});
            plain_q.push_back('{64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001});
            drain();
        end
        // Ignored register index must leave the key alone.
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= 3'd7; cfg_wdata <= {$urandom, $urandom};
        @(posedge aclk);
        cfg_we <= 1'b0;
        plain_q.push_back('{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210});
        drain();

        // Random phases: fresh key and mode each time.
        for (int ph = 0; ph < 12; ph++) begin
            set_key(modes[$urandom_range(3)], 1'b0, '0);
            idle_on = (ph != 3);
            if (ph == 5) hold_rx = 1'b1;
            queue_random(95);
            drain();
        end

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/aes_pkg.sv
rtl/aes_cell.sv
rtl/aes_block_encrypt_top.sv
dv/aes_block_encrypt_top_tb.sv
